FILE: rtl/core/growing_window_mean_subtraction_assert.svh
// ----------------------------------------------------------------------------
// growing window mean subtraction assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef GROWING_WINDOW_MEAN_SUBTRACTION_ASSERT_SVH
`define GROWING_WINDOW_MEAN_SUBTRACTION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GWMS_ASSERT_IMPLIES(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("gwms same-cycle check failed");

// next-cycle implication
`define GWMS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("gwms next-cycle check failed");

`else

`define GWMS_ASSERT_IMPLIES(label, pre, post)
`define GWMS_ASSERT_NEXT(label, pre, post)

`endif

`endif

FILE: rtl/core/gwms_pkg.sv
// ----------------------------------------------------------------------------
// gwms_pkg
// shared widths, register map and divider interface types
// ----------------------------------------------------------------------------
package gwms_pkg;

	localparam int MAX_FEATURES = 64;
	localparam int POS_W        = $clog2(MAX_FEATURES);
	localparam int LEN_W        = 7;
	localparam int FEAT_W       = 16;
	localparam int NORM_W       = 17;
	localparam int MEAN_W       = 24;
	localparam int CNT_W        = 16;
	localparam int RECIP_W      = 17;
	localparam int PADDR_W      = 2;
	localparam int PDATA_W      = 32;

	localparam logic [LEN_W-1:0]   FRAME_LENGTH_RESET = 7'd13;
	localparam logic [PADDR_W-1:0] ADDR_FRAME_LENGTH  = 2'd0;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RECIP_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/core/gwms_recip_div.sv
// ----------------------------------------------------------------------------
// gwms_recip_div
// restoring divider forming round(65536 / count), one quotient bit a cycle
// ----------------------------------------------------------------------------
module gwms_recip_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gwms_pkg::div_req_t req,
	output gwms_pkg::div_rsp_t rsp
);
	import gwms_pkg::*;

	localparam int STEP_W = $clog2(RECIP_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RECIP_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [RECIP_W-1:0]  dividend_q;
	logic [RECIP_W-1:0]  rem_q;
	logic [RECIP_W-1:0]  quo_q;
	logic [CNT_W-1:0]    divisor_q;
	logic [RECIP_W-1:0]  trial;
	logic                fits;

	// remainder stays below the divisor, so the shifted value fits
	assign trial = {rem_q[RECIP_W-2:0], dividend_q[RECIP_W-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			step_q     <= '0;
			dividend_q <= '0;
			rem_q      <= '0;
			quo_q      <= '0;
			divisor_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q     <= 1'b1;
				step_q     <= '0;
				rem_q      <= '0;
				divisor_q  <= req.count;
				// 65536 + count/2 gives round-half-up
				dividend_q <= {1'b1, {(RECIP_W-1){1'b0}}} + {2'b00, req.count[CNT_W-1:1]};
			end else if (busy_q) begin
				dividend_q <= {dividend_q[RECIP_W-2:0], 1'b0};
				rem_q      <= fits ? (trial - {1'b0, divisor_q}) : trial;
				quo_q      <= {quo_q[RECIP_W-2:0], fits};
				step_q     <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: rtl/core/growing_window_mean_subtraction.sv
// ----------------------------------------------------------------------------
// growing_window_mean_subtraction
// per-position running mean over feature frames, subtracted from each element
// ----------------------------------------------------------------------------
// One word is worked at a time. For an element at a frame position other than
// the first, the mean memory is read at acceptance, the product is registered,
// then the update writes back and loads the output register. The first element
// of a frame also forms the frame's reciprocal in a restoring divider, one bit
// a cycle for its 17 quotient bits, and the quotient is registered before the
// product step. The next word is taken as soon as the result sits in the
// output register, even while that register is stalled; a stalled output
// holds the block in its update step. The 64-entry mean memory needs no
// clearing pass: a valid bit per entry, cleared at reset, makes unwritten
// entries read as zero.
module growing_window_mean_subtraction (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gwms_pkg::PADDR_W-1:0]      paddr,
	input  logic [gwms_pkg::PDATA_W-1:0]      pwdata,
	output logic [gwms_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [gwms_pkg::FEAT_W-1:0] feature_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [gwms_pkg::NORM_W-1:0] normalized_value,
	output logic                              last_of_frame
);
	import gwms_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_UPD
	} state_t;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FEATURES);

	state_t                    state_q;
	logic [LEN_W-1:0]          frame_length_q;
	logic [CNT_W-1:0]          frames_seen_q;
	logic [POS_W-1:0]          pos_q;
	logic [RECIP_W-1:0]        recip_q;
	logic signed [FEAT_W-1:0]  x_q;
	logic                      out_valid_q;
	logic signed [NORM_W-1:0]  norm_q;
	logic                      last_q;
	logic [MAX_FEATURES-1:0]   valid_q;

	logic [MEAN_W-1:0]         mean_mem [MAX_FEATURES];
	logic [MEAN_W-1:0]         mean_raw_s1;
	logic                      mean_hit_s1;
	logic signed [42:0]        prod_s2;

	logic                      accept;
	logic                      cfg_write;
	logic [LEN_W-1:0]          eff_len;
	logic                      last;
	logic [CNT_W-1:0]          frames_next;
	logic                      out_free;
	logic                      commit;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	logic signed [MEAN_W-1:0]  mean_old;
	logic signed [MEAN_W-1:0]  x_scaled;
	logic signed [MEAN_W:0]    diff;
	logic signed [42:0]        prod;
	logic signed [42:0]        prod_rnd;
	logic signed [26:0]        delta;
	logic signed [27:0]        mean_sum;
	logic signed [MEAN_W-1:0]  mean_new;
	logic signed [MEAN_W:0]    mean_rnd;
	logic signed [NORM_W-1:0]  rmean;
	logic signed [NORM_W:0]    result;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr == ADDR_FRAME_LENGTH) ?
		{{(PDATA_W-LEN_W){1'b0}}, frame_length_q} : '0;

	always_comb begin
		if (frame_length_q == '0)
			eff_len = LEN_W'(1);
		else if (frame_length_q > MAX_LEN)
			eff_len = MAX_LEN;
		else
			eff_len = frame_length_q;
	end

	assign last        = (({1'b0, pos_q} + 1'b1) >= eff_len);
	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign frames_next = (frames_seen_q == '1) ? frames_seen_q : frames_seen_q + 1'b1;
	assign out_free    = !out_valid_q || !out_stall;
	assign commit      = (state_q == S_UPD) && out_free;

	assign div_req.start = accept && (pos_q == '0);
	assign div_req.count = frames_next;

	gwms_recip_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// datapath
	assign mean_old = mean_hit_s1 ? mean_raw_s1 : '0;
	assign x_scaled = {x_q, 8'h00};
	assign diff     = {x_scaled[MEAN_W-1], x_scaled} - {mean_old[MEAN_W-1], mean_old};
	assign prod     = diff * $signed({1'b0, recip_q});
	assign prod_rnd = prod_s2 + 43'sd32768;
	assign delta    = prod_rnd[42:16];
	assign mean_sum = {{4{mean_old[MEAN_W-1]}}, mean_old} + {delta[26], delta};

	always_comb begin
		if (mean_sum > 28'sd8388607)
			mean_new = 24'h7FFFFF;
		else if (mean_sum < -28'sd8388608)
			mean_new = 24'h800000;
		else
			mean_new = mean_sum[MEAN_W-1:0];
	end

	assign mean_rnd = {mean_new[MEAN_W-1], mean_new} + 25'sd128;
	assign rmean    = mean_rnd[MEAN_W:8];
	assign result   = {{2{x_q[FEAT_W-1]}}, x_q} - {rmean[NORM_W-1], rmean};

	// mean memory, read on accept, written on commit
	always_ff @(posedge clk) begin
		if (accept)
			mean_raw_s1 <= mean_mem[pos_q];
		if (commit)
			mean_mem[pos_q] <= mean_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			frame_length_q <= FRAME_LENGTH_RESET;
			frames_seen_q  <= '0;
			pos_q          <= '0;
			recip_q        <= '0;
			x_q            <= '0;
			mean_hit_s1    <= 1'b0;
			prod_s2        <= '0;
			valid_q        <= '0;
			out_valid_q    <= 1'b0;
			norm_q         <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_write && paddr == ADDR_FRAME_LENGTH)
				frame_length_q <= pwdata[LEN_W-1:0];
			if (commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						x_q         <= feature_value;
						mean_hit_s1 <= valid_q[pos_q];
						if (pos_q == '0) begin
							frames_seen_q <= frames_next;
							state_q       <= S_DIV;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						recip_q <= div_rsp.quotient;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_s2 <= prod;
					state_q <= S_UPD;
				end
				S_UPD: begin
					// hold here while the previous word is still stalled
					if (out_free) begin
						valid_q[pos_q] <= 1'b1;
						norm_q         <= result[NORM_W-1:0];
						last_q         <= last;
						pos_q          <= last ? '0 : pos_q + 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign normalized_value = norm_q;
	assign last_of_frame    = last_q;

`include "growing_window_mean_subtraction_assert.svh"

	`GWMS_ASSERT_NEXT(a_first_elem_divides, accept && pos_q == '0, state_q == S_DIV)
	`GWMS_ASSERT_IMPLIES(a_div_done_only_in_div, div_rsp.done, state_q == S_DIV)
	`GWMS_ASSERT_IMPLIES(a_recip_formed, state_q == S_MUL, recip_q != '0 && frames_seen_q != '0)
	`GWMS_ASSERT_NEXT(a_commit_loads_out, commit, out_valid_q && state_q == S_IDLE)

endmodule
